// File: design/clt_pkg.sv
// Package for the compacting list table: sizes, opcode and status codes,
// sequencer states and the request/result payload structs.
// No dependencies; imported by compacting_list_table.
package clt_pkg;

    localparam int DEPTH     = 16;
    localparam int AW        = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int VAL_W     = 31;
    localparam int STS_W     = 3;
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CAP_RESET = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_LIST   = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_SEARCH = 3'd4
    } opcode_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_EMPTY     = 3'd2,
        STS_BAD_POS   = 3'd3,
        STS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_LIST_RD,
        ST_LIST_OUT,
        ST_SEARCH,
        ST_DELETE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } clt_in_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [POS_W-1:0] found_position;
        logic [VAL_W-1:0] entry_value;
        logic             last;
    } clt_out_t;

endpackage

// File: design/clt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module clt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/compacting_list_table.sv
// Top level of the compacting list table: an ordered list of identifiers in
// one RAM with a fill count. Depends on clt_pkg and clt_ram.
//
//   channel  | ports                          | direction | payload
//   ---------+--------------------------------+-----------+----------------------
//   request  | s_valid / s_ready / s_data     | in        | clt_in_t (op,pos,val)
//   result   | m_valid / m_ready / m_data     | out       | clt_out_t
//   config   | cfg_valid / cfg_ready / cfg_data | in      | capacity_limit
//
// Pace: append, update, a delete of the last entry and every error result go
//   straight to the result; search walks the list up to the hit, or to the
//   end on a miss; any other delete shifts every entry after the position
//   down by one; list reads and emits one entry at a time. The single
//   read port of the entry RAM sets the pace: search and delete read one entry
//   per cycle, and the registered read data returns in the next cycle.
// Reset: the fill count clears and the limit returns to 16. RAM contents are
//   undefined until written; cells at or above the fill count are never read.
// Stalls: the result register holds while m_ready is low. A new request is
//   taken once the sequencer is back in idle, even while a result still waits.
module compacting_list_table
    import clt_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  clt_in_t        s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output clt_out_t       m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    // Sequencer and bookkeeping registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    clt_out_t           res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    clt_out_t           m_data_reg, m_data_next;

    // Entry RAM port.
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VAL_W-1:0]   ram_wdata, ram_rdata;

    // Decode of the incoming request against the current fill count.
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   pos_ext, cnt_ext, pos_m1;
    logic               is_empty, is_full, pos_bad, del_noshift;
    logic               slot_free, rd_issue, pend_last, srch_hit;
    logic               out_load;
    clt_out_t           out_data;
    logic [CNT_W-1:0]   pend_ext;

    clt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Saturate the limit to the RAM depth.
    assign limit = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign pos_ext     = CMP_W'(s_data.position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign pos_m1      = pos_ext - CMP_W'(1);
    assign is_empty    = (count_reg == '0);
    assign is_full     = (cnt_ext >= limit);
    assign pos_bad     = (pos_ext == '0) || (pos_ext > cnt_ext);
    assign del_noshift = (pos_ext == cnt_ext);

    assign slot_free = !m_valid_reg || m_ready;
    assign rd_issue  = (rd_idx_reg < count_reg);
    assign pend_ext  = CNT_W'(pend_idx_reg);
    assign pend_last = (pend_ext == count_reg - CNT_W'(1));
    assign srch_hit  = (ram_rdata == val_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.opcode)
                        OP_APPEND, OP_UPDATE: state_next = ST_RESP;
                        OP_LIST:   state_next = is_empty ? ST_RESP : ST_LIST_RD;
                        OP_SEARCH: state_next = is_empty ? ST_RESP : ST_SEARCH;
                        OP_DELETE: begin
                            if (is_empty || pos_bad || del_noshift) begin
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_DELETE;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST_RD: state_next = ST_LIST_OUT;
            ST_LIST_OUT: begin
                if (slot_free) begin
                    state_next = pend_last ? ST_IDLE : ST_LIST_RD;
                end
            end
            ST_SEARCH: begin
                if (rd_pend_reg && (srch_hit || pend_last)) begin
                    state_next = ST_RESP;
                end
            end
            ST_DELETE: begin
                if (rd_pend_reg && pend_last) begin
                    state_next = ST_RESP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM port and result emission.
    always_comb begin
        count_next    = count_reg;
        cap_next      = cfg_valid ? cfg_data : cap_reg;
        rd_idx_next   = rd_idx_reg;
        pend_idx_next = pend_idx_reg;
        rd_pend_next  = rd_pend_reg;
        val_next      = val_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = s_data.value;
        ram_re        = 1'b0;
        ram_raddr     = rd_idx_reg[AW-1:0];
        out_load      = 1'b0;
        out_data      = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next     = s_data.value;
                    rd_idx_next  = '0;
                    rd_pend_next = 1'b0;
                    res_next     = '{status: STS_OK, found_position: '0,
                                     entry_value: '0, last: 1'b1};
                    case (s_data.opcode)
                        OP_APPEND: begin
                            if (is_full) begin
                                res_next.status = STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_LIST: begin
                            if (is_empty) begin
                                res_next.status = STS_EMPTY;
                            end
                        end
                        OP_UPDATE: begin
                            if (is_empty) begin
                                res_next.status = STS_EMPTY;
                            end else if (pos_bad) begin
                                res_next.status = STS_BAD_POS;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_m1[AW-1:0];
                            end
                        end
                        OP_DELETE: begin
                            if (is_empty) begin
                                res_next.status = STS_EMPTY;
                            end else if (pos_bad) begin
                                res_next.status = STS_BAD_POS;
                            end else if (del_noshift) begin
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                // Start the shift with the entry after the hole.
                                rd_idx_next = CNT_W'(pos_ext);
                            end
                        end
                        OP_SEARCH: begin
                            res_next.entry_value = s_data.value;
                            if (is_empty) begin
                                res_next.status = STS_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESP: begin
                out_load = slot_free;
            end
            ST_LIST_RD: begin
                ram_re        = 1'b1;
                pend_idx_next = rd_idx_reg[AW-1:0];
                rd_idx_next   = rd_idx_reg + CNT_W'(1);
            end
            ST_LIST_OUT: begin
                out_load = slot_free;
                out_data = '{status: STS_OK,
                             found_position: POS_W'(pend_ext + CNT_W'(1)),
                             entry_value: ram_rdata, last: pend_last};
            end
            ST_SEARCH: begin
                // Issue one read per cycle; compare the one that just returned.
                ram_re       = rd_issue;
                rd_pend_next = rd_issue;
                if (rd_issue) begin
                    pend_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    if (srch_hit) begin
                        res_next.found_position = POS_W'(pend_ext + CNT_W'(1));
                    end else if (pend_last) begin
                        res_next.status = STS_NOT_FOUND;
                    end
                end
            end
            ST_DELETE: begin
                // Read entry i, write it back to i-1 on the next cycle.
                ram_re       = rd_issue;
                rd_pend_next = rd_issue;
                if (rd_issue) begin
                    pend_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                    if (pend_last) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase

        // Result register: load when free, drop when taken.
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = out_data;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_W'(CAP_RESET);
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // The fill count never exceeds the RAM depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Listing and searching never modify the RAM.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE || state_reg == ST_DELETE))
        else $error("RAM write outside append, update or delete");

    // A shift never reads and writes the same entry in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide");

    // A returning read always belongs to a stored entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DELETE || state_reg == ST_SEARCH) && rd_pend_reg)
            |-> (pend_ext < count_reg))
        else $error("read beyond fill count");

    // The count only moves by one step per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill count jumped");

endmodule

// File: sim/tb_compacting_list_table.sv
// Self-checking testbench for compacting_list_table: a queue-fed request driver that
// updates a list predictor, a result monitor, and capacity writes between traffic phases.
// Depends on clt_pkg and the compacting_list_table RTL.
`timescale 1ns / 1ps

module tb_compacting_list_table;
    import clt_pkg::*;

    localparam int                 WATCHDOG_LIMIT = 2000;
    localparam int                 SETTLE_CYCLES  = 48;
    localparam int                 RANDOM_PHASES  = 9;
    localparam int                 PHASE_ITEMS    = 45;
    // opcodes the block decodes to nothing
    localparam logic [OP_W-1:0]    OP_RSVD_5      = 3'd5;
    localparam logic [OP_W-1:0]    OP_RSVD_6      = 3'd6;
    localparam logic [OP_W-1:0]    OP_RSVD_7      = 3'd7;
    localparam logic [VAL_W-1:0]   VAL_MAX        = {VAL_W{1'b1}};

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    clt_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    clt_out_t         m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    compacting_list_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the list as the block should hold it
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] list_cells [DEPTH];
    int               list_len = 0;
    logic [CAP_W-1:0] capacity = CAP_RESET;

    clt_in_t  pending_requests [$];
    clt_out_t expected_results [$];

    int error_count = 0;
    int src_gap     = 0;
    int sink_gap    = 0;
    bit steady      = 1'b0;   // phase without idling on either side

    logic [VAL_W-1:0] value_pool [8] = '{
        '0, VAL_MAX, 31'h1, 31'h40000000,
        31'h12345678, 31'h55555555, 31'h2AAAAAAA, 31'h0000BEEF
    };

    function automatic int effective_limit();
        return (capacity > DEPTH) ? DEPTH : int'(capacity);
    endfunction

    function automatic void push_result(status_t sts, int pos, logic [VAL_W-1:0] val,
                                        bit is_last);
        clt_out_t r;
        r.status         = sts;
        r.found_position = pos[POS_W-1:0];
        r.entry_value    = val;
        r.last           = is_last;
        expected_results.push_back(r);
    endfunction

    // Work out every result one accepted request causes, and update the list.
    function automatic void apply_request(clt_in_t req);
        int idx;
        int hit;
        hit = 0;
        case (req.opcode)
            OP_APPEND: begin
                if (list_len >= effective_limit()) begin
                    push_result(STS_FULL, 0, '0, 1'b1);
                end else begin
                    list_cells[list_len] = req.value;
                    list_len++;
                    push_result(STS_OK, 0, '0, 1'b1);
                end
            end
            OP_LIST: begin
                if (list_len == 0) begin
                    push_result(STS_EMPTY, 0, '0, 1'b1);
                end else begin
                    for (idx = 0; idx < list_len; idx++)
                        push_result(STS_OK, idx + 1, list_cells[idx], idx + 1 == list_len);
                end
            end
            OP_UPDATE, OP_DELETE: begin
                if (list_len == 0) begin
                    push_result(STS_EMPTY, 0, '0, 1'b1);
                end else if (req.position == 0 || req.position > list_len) begin
                    push_result(STS_BAD_POS, 0, '0, 1'b1);
                end else begin
                    if (req.opcode == OP_UPDATE) begin
                        list_cells[req.position - 1] = req.value;
                    end else begin
                        for (idx = req.position - 1; idx + 1 < list_len; idx++)
                            list_cells[idx] = list_cells[idx + 1];
                        list_len--;
                    end
                    push_result(STS_OK, 0, '0, 1'b1);
                end
            end
            OP_SEARCH: begin
                if (list_len == 0) begin
                    push_result(STS_EMPTY, 0, req.value, 1'b1);
                end else begin
                    for (idx = 0; idx < list_len && hit == 0; idx++)
                        if (list_cells[idx] == req.value)
                            hit = idx + 1;
                    push_result(hit != 0 ? STS_OK : STS_NOT_FOUND, hit, req.value, 1'b1);
                end
            end
            default: ;   // unused opcodes: no result, no change
        endcase
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pop the next request, hold it until accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_driver
        logic    next_valid;
        clt_in_t next_data;
        next_valid = s_valid;
        next_data  = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_data);
                next_valid = 1'b0;
            end
            // a back-to-back request keeps valid high; never drop and raise in one step
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_requests.size() > 0) begin
                    next_data  = pending_requests.pop_front();
                    next_valid = 1'b1;
                    src_gap    = pick_gap();
                end
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        clt_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none actual %0h",
                             $time, m_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("found_position", want.found_position,
                                m_data.found_position);
                    check_field("entry_value", want.entry_value, m_data.entry_value);
                    check_field("last", want.last, m_data.last);
                end
            end
            // stall the result channel in random bursts
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
        clt_in_t req;
        req.opcode   = op;
        req.position = pos;
        req.value    = val;
        pending_requests.push_back(req);
    endtask

    // Wait until every request is taken and every result has come back, then
    // give the block time to finish any request that causes no result.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        capacity = cap;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [OP_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return OP_APPEND;
        if (r < 52) return OP_LIST;
        if (r < 66) return OP_UPDATE;
        if (r < 82) return OP_DELETE;
        if (r < 96) return OP_SEARCH;
        if (r < 97) return OP_RSVD_5;
        if (r < 98) return OP_RSVD_6;
        return OP_RSVD_7;
    endfunction

    // Queue a phase of mostly well-formed requests. Track the list length
    // alongside so positions land inside the list most of the time.
    task automatic queue_random_phase(int item_total);
        int               live;
        int               len_guess;
        int               r;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        live      = 0;
        len_guess = list_len;
        while (live < item_total) begin
            op = pick_opcode();
            r  = $urandom_range(0, 99);
            if (r < 80 && len_guess > 0)
                pos = POS_W'($urandom_range(1, len_guess));
            else if (r < 90)
                pos = '0;
            else
                pos = POS_W'($urandom_range(len_guess < 31 ? len_guess + 1 : 31, 31));
            val = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)]
                                                : VAL_W'($urandom());
            queue_request(op, pos, val);
            if (op == OP_APPEND && len_guess < effective_limit())
                len_guess++;
            if (op == OP_DELETE && pos >= 1 && pos <= len_guess)
                len_guess--;
            if (op <= OP_SEARCH)
                live++;
        end
    endtask

    logic [CAP_W-1:0] phase_caps [RANDOM_PHASES] = '{
        5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2, 5'd12, 5'd20, 5'd9
    };

    initial begin : stimulus
        int ph;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty list first, then field extremes and the empty, bad-position and not-found errors.
        queue_request(OP_LIST,   '0,    '0);
        queue_request(OP_SEARCH, '0,    VAL_MAX);
        queue_request(OP_UPDATE, 5'd1,  31'h5);
        queue_request(OP_DELETE, 5'd0,  '0);
        queue_request(OP_APPEND, '1,    '0);
        queue_request(OP_APPEND, 5'd0,  VAL_MAX);
        queue_request(OP_APPEND, 5'd16, 31'h55555555);
        queue_request(OP_APPEND, 5'd3,  31'h2AAAAAAA);
        queue_request(OP_LIST,   '0,    '0);
        queue_request(OP_SEARCH, '0,    VAL_MAX);
        queue_request(OP_SEARCH, '0,    31'h12345678);
        queue_request(OP_UPDATE, 5'd0,  31'h7);
        queue_request(OP_UPDATE, '1,    31'h7);
        queue_request(OP_UPDATE, 5'd5,  31'h7);
        queue_request(OP_UPDATE, 5'd4,  VAL_MAX);
        queue_request(OP_SEARCH, '0,    VAL_MAX);   // duplicate: first position wins
        queue_request(OP_DELETE, 5'd1,  '0);
        queue_request(OP_DELETE, 5'd3,  '0);
        queue_request(OP_DELETE, 5'd3,  '0);        // now past the end
        queue_request(OP_RSVD_5, 5'd1,  VAL_MAX);
        queue_request(OP_RSVD_7, '1,    '0);
        queue_request(OP_RSVD_6, 5'd2,  31'h1);
        queue_request(OP_LIST,   '0,    '0);
        queue_request(OP_SEARCH, '0,    '0);
        wait_drained();

        // Random phases, each under its own capacity setting.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_capacity(phase_caps[ph]);
            steady = ($urandom_range(0, 3) == 0);
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
